// ===== hw/rtl/tdq_pkg.sv =====
`default_nettype none
package tdq_pkg;

   localparam int TimerSlotsDefault = 32;
   localparam int IdBitsDefault     = 16;
   localparam int ResultCap         = 32;
   localparam int TimeBits          = 48;
   localparam int PeriodBits        = 32;
   localparam logic [TimeBits-1:0] TimeMax = '1;

   typedef enum logic [1:0] {
      REQ_ADD  = 2'd0,
      REQ_DEL  = 2'd1,
      REQ_TICK = 2'd2,
      REQ_NONE = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] timer_id;
      logic [47:0] deadline;
      logic [31:0] repeat_period;
      logic [47:0] current_time;
   } req_type;

   typedef struct packed {
      logic        fired_valid;
      logic [15:0] fired_id;
      logic        rearmed;
      logic        table_full;
      logic        queue_empty;
      logic [47:0] next_deadline;
      logic        last;
   } rsp_type;

   // Control state of the sequencer.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_EMIT,
      ST_DONE
   } state_type;

   // Result of one sweep over the table.
   typedef struct packed {
      logic        hit;
      logic        free_found;
      logic        due_found;
      logic        any_valid;
      logic [47:0] min_deadline;
   } scan_sum_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tdq_store.sv =====
`default_nettype none
module tdq_store
   import tdq_pkg::*;
#(
   parameter int TIMER_SLOTS = TimerSlotsDefault,
   parameter int ID_BITS     = IdBitsDefault,
   localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [AW-1:0]      rd_addr,
   output logic                    rd_valid,
   output logic [ID_BITS-1:0]      rd_id,
   output logic [TimeBits-1:0]     rd_deadline,
   output logic [PeriodBits-1:0]   rd_period,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic               wr_valid,
   input  wire logic [ID_BITS-1:0] wr_id,
   input  wire logic [TimeBits-1:0]   wr_deadline,
   input  wire logic [PeriodBits-1:0] wr_period
);

   // Payload memory, registered read.
   logic [ID_BITS+TimeBits+PeriodBits-1:0] mem [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0] valid_ff;
   logic [ID_BITS+TimeBits+PeriodBits-1:0] rd_word_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_id, wr_deadline, wr_period};
      end
      rd_word_ff <= mem[rd_addr];
   end

   // Valid bits in flip-flops so that reset empties the table at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= wr_valid;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_valid    = rd_valid_ff;
   assign rd_id       = rd_word_ff[ID_BITS+TimeBits+PeriodBits-1 -: ID_BITS];
   assign rd_deadline = rd_word_ff[TimeBits+PeriodBits-1 -: TimeBits];
   assign rd_period   = rd_word_ff[PeriodBits-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/timer_deadline_queue_top.sv =====
`default_nettype none
// Channel    Ports                          Direction  Handshake
// request    req_payload, start, busy       in         start && !busy
// response   rsp_payload, rsp_strobe        out        strobe, one cycle
//
// Every request sweeps the entry memory through its one read port, one entry a
// cycle; each sweep ends in an update state. An add or delete sweeps, writes, then
// sweeps again for the new minimum. A tick sweeps once per fired timer and once
// more, then gives one response a cycle; an unused request type sweeps once.
// After reset the table is empty at once. Responses cannot be held off; busy stays
// high until the last one.
module timer_deadline_queue_top
   import tdq_pkg::*;
#(
   parameter int TIMER_SLOTS = TimerSlotsDefault,
   parameter int ID_BITS     = IdBitsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload
);

   localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 2);
   localparam int NW = $clog2(ResultCap + 1);
   localparam int LW = $clog2(ResultCap);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] emit_ff, emit_in;
   logic [TIMER_SLOTS-1:0] done_ff;
   logic [NW-1:0] fired_ff;
   scan_sum_type sum_ff;
   logic [AW-1:0] hit_ff, free_ff, best_ff;
   logic [ID_BITS-1:0] best_id_ff;
   logic [TimeBits-1:0] best_dl_ff;
   logic [PeriodBits-1:0] best_per_ff;
   logic final_ff;
   logic full_ff;

   logic [AW-1:0] rd_addr, rd_slot;
   logic rd_valid;
   logic [ID_BITS-1:0] rd_id;
   logic [TimeBits-1:0] rd_deadline;
   logic [PeriodBits-1:0] rd_period;
   logic wr_en, wr_valid;
   logic [AW-1:0] wr_addr;
   logic [ID_BITS-1:0] wr_id;
   logic [TimeBits-1:0] wr_deadline;
   logic [PeriodBits-1:0] wr_period;

   logic [ID_BITS-1:0] req_id;
   logic rd_live, rd_due, better;
   logic [TimeBits:0] rearm_sum;
   logic [TimeBits-1:0] rearm_dl;
   logic is_edit, fire_now;

   // Log of fired timers, replayed once the table has settled.
   logic [ID_BITS:0] log_mem [ResultCap];
   logic [ID_BITS:0] log_rd_ff;

   assign req_id  = ID_BITS'(req_ff.timer_id);
   assign rd_addr = cnt_ff[AW-1:0];
   assign rd_live = (state_ff == ST_SCAN) && (cnt_ff >= CW'(1))
                    && (cnt_ff <= CW'(TIMER_SLOTS));
   assign rd_slot = AW'(cnt_ff - CW'(1));
   assign rd_due  = rd_valid && !done_ff[rd_slot]
                    && (rd_deadline <= req_ff.current_time);
   assign better  = !sum_ff.due_found || (rd_deadline < best_dl_ff)
                    || ((rd_deadline == best_dl_ff) && (rd_id < best_id_ff));
   assign rearm_sum = {1'b0, req_ff.current_time} + {{(TimeBits-PeriodBits+1){1'b0}},
                                                      best_per_ff};
   assign rearm_dl  = rearm_sum[TimeBits] ? TimeMax : rearm_sum[TimeBits-1:0];
   assign is_edit   = (req_ff.req_type == REQ_ADD) || (req_ff.req_type == REQ_DEL);
   assign fire_now  = (state_ff == ST_APPLY) && (req_ff.req_type == REQ_TICK)
                      && sum_ff.due_found;

   tdq_store #(.TIMER_SLOTS(TIMER_SLOTS), .ID_BITS(ID_BITS)) u_store (
      .clock, .reset, .rd_addr, .rd_valid, .rd_id, .rd_deadline, .rd_period,
      .wr_en, .wr_addr, .wr_valid, .wr_id, .wr_deadline, .wr_period
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      emit_in  = emit_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(TIMER_SLOTS)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cnt_in  = '0;
            emit_in = '0;
            // A firing or an edit is followed by a fresh sweep of the updated table.
            if (fire_now || (is_edit && !final_ff)) begin
               state_in = ST_SCAN;
            end else if (fired_ff != '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EMIT: begin
            emit_in = emit_ff + NW'(1);
            if (emit_ff == fired_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory write.
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = best_ff;
      wr_valid    = 1'b0;
      wr_id       = req_id;
      wr_deadline = req_ff.deadline;
      wr_period   = req_ff.repeat_period;
      if (state_ff == ST_APPLY) begin
         case (req_ff.req_type)
            REQ_ADD: begin
               wr_en    = !final_ff && (sum_ff.hit || sum_ff.free_found);
               wr_addr  = sum_ff.hit ? hit_ff : free_ff;
               wr_valid = 1'b1;
            end
            REQ_DEL: begin
               wr_en    = !final_ff && sum_ff.hit;
               wr_addr  = hit_ff;
               wr_valid = 1'b0;
            end
            REQ_TICK: begin
               wr_en       = sum_ff.due_found;
               wr_addr     = best_ff;
               wr_valid    = best_per_ff != '0;
               wr_id       = best_id_ff;
               wr_deadline = rearm_dl;
               wr_period   = best_per_ff;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         emit_ff  <= '0;
         fired_ff <= '0;
         done_ff  <= '0;
         final_ff <= 1'b0;
         full_ff  <= 1'b0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         emit_ff  <= emit_in;
         if (state_ff == ST_IDLE && start) begin
            fired_ff <= '0;
            done_ff  <= '0;
            final_ff <= 1'b0;
            full_ff  <= 1'b0;
         end
         if (state_ff == ST_SCAN && cnt_ff == '0) begin
            sum_ff <= '0;
         end else if (rd_live) begin
            if (rd_valid) begin
               sum_ff.any_valid <= 1'b1;
               if (!sum_ff.any_valid || rd_deadline < sum_ff.min_deadline) begin
                  sum_ff.min_deadline <= rd_deadline;
               end
               if (rd_id == req_id) begin
                  sum_ff.hit <= 1'b1;
                  hit_ff     <= rd_slot;
               end
            end else if (!sum_ff.free_found) begin
               sum_ff.free_found <= 1'b1;
               free_ff           <= rd_slot;
            end
            if (rd_due && better && fired_ff < NW'(ResultCap)) begin
               sum_ff.due_found <= 1'b1;
               best_ff     <= rd_slot;
               best_id_ff  <= rd_id;
               best_dl_ff  <= rd_deadline;
               best_per_ff <= rd_period;
            end
         end
         if (state_ff == ST_APPLY) begin
            if (is_edit) begin
               final_ff <= 1'b1;
            end
            if (req_ff.req_type == REQ_ADD && !final_ff) begin
               full_ff <= !sum_ff.hit && !sum_ff.free_found;
            end
            if (fire_now) begin
               done_ff[best_ff] <= 1'b1;
               fired_ff         <= fired_ff + NW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_payload;
      end
   end

   // Each firing is logged with its re-arm flag; the log is read one entry ahead.
   always_ff @(posedge clock) begin
      if (fire_now) begin
         log_mem[fired_ff[LW-1:0]] <= {best_id_ff, best_per_ff != '0};
      end
      log_rd_ff <= log_mem[emit_ff[LW-1:0]];
   end

   // Responses carry the minimum and empty flag of the final sweep.
   always_comb begin
      rsp_strobe  = 1'b0;
      rsp_payload = '0;
      rsp_payload.queue_empty   = !sum_ff.any_valid;
      rsp_payload.next_deadline = sum_ff.any_valid ? sum_ff.min_deadline : '0;
      case (state_ff)
         ST_EMIT: begin
            if (emit_ff != '0) begin
               rsp_strobe              = 1'b1;
               rsp_payload.fired_valid = 1'b1;
               rsp_payload.fired_id    = 16'(log_rd_ff[ID_BITS:1]);
               rsp_payload.rearmed     = log_rd_ff[0];
               rsp_payload.last        = emit_ff == fired_ff;
            end
         end
         ST_DONE: begin
            rsp_strobe             = 1'b1;
            rsp_payload.last       = 1'b1;
            rsp_payload.table_full = full_ff;
         end
         default: begin
            rsp_strobe = 1'b0;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response outside a transaction");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> !busy)
      else $error("transaction did not close");
   assert property (@(posedge clock) disable iff (reset)
      fired_ff <= NW'(ResultCap))
      else $error("fired count beyond cap");

endmodule
`default_nettype wire

// ===== verif/timer_deadline_queue_top_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module timer_deadline_queue_top_tb;
   import tdq_pkg::*;

   localparam int Slots = 32;
   localparam int CycleLimit = 1500000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   timer_deadline_queue_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
   );

   always #6 clock = ~clock;

   // Shadow copy of the timer table.
   logic        tbl_valid [Slots];
   logic [15:0] tbl_id    [Slots];
   logic [47:0] tbl_when  [Slots];
   logic [31:0] tbl_per   [Slots];

   req_type pending_reqs[$];
   rsp_type due_rsps[$];
   int      send_idle_pct = 0;
   bit      hold_sender = 1'b0;
   int      failures = 0;
   int      cycles = 0;
   bit      stim_done = 1'b0;

   // Work out the responses that one request causes and update the shadow table.
   task automatic predict_timers(input req_type r);
      int          slot;
      int          best;
      int          fired;
      bit          full;
      bit          any;
      bit          handled [Slots];
      logic [15:0] ids [ResultCap];
      bit          rea [ResultCap];
      logic [47:0] nxt;
      logic [48:0] sum;
      rsp_type     p;
      slot = -1; fired = 0; full = 1'b0; any = 1'b0; nxt = '0;
      for (int i = 0; i < Slots; i++) handled[i] = 1'b0;
      case (req_code_type'(r.req_type))
         REQ_ADD: begin
            for (int i = 0; i < Slots; i++)
               if (slot < 0 && tbl_valid[i] && tbl_id[i] == r.timer_id) slot = i;
            for (int i = 0; i < Slots; i++)
               if (slot < 0 && !tbl_valid[i]) slot = i;
            if (slot < 0) begin
               full = 1'b1;
            end else begin
               tbl_valid[slot] = 1'b1; tbl_id[slot] = r.timer_id;
               tbl_when[slot] = r.deadline; tbl_per[slot] = r.repeat_period;
            end
         end
         REQ_DEL: begin
            for (int i = 0; i < Slots; i++)
               if (tbl_valid[i] && tbl_id[i] == r.timer_id) tbl_valid[i] = 1'b0;
         end
         REQ_TICK: begin
            while (fired < ResultCap) begin
               best = -1;
               for (int i = 0; i < Slots; i++) begin
                  if (!tbl_valid[i] || handled[i] || tbl_when[i] > r.current_time) continue;
                  if (best < 0 || tbl_when[i] < tbl_when[best] ||
                      (tbl_when[i] == tbl_when[best] && tbl_id[i] < tbl_id[best]))
                     best = i;
               end
               if (best < 0) break;
               ids[fired] = tbl_id[best];
               if (tbl_per[best] != 0) begin
                  sum = {1'b0, r.current_time} + 49'(tbl_per[best]);
                  tbl_when[best] = sum[48] ? TimeMax : sum[47:0];
                  handled[best] = 1'b1;
                  rea[fired] = 1'b1;
               end else begin
                  tbl_valid[best] = 1'b0;
                  rea[fired] = 1'b0;
               end
               fired++;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < Slots; i++)
         if (tbl_valid[i] && (!any || tbl_when[i] < nxt)) begin
            nxt = tbl_when[i]; any = 1'b1;
         end
      p = '0;
      p.queue_empty = !any;
      p.next_deadline = nxt;
      if (fired == 0) begin
         p.table_full = full; p.last = 1'b1;
         due_rsps.push_back(p);
      end else begin
         for (int k = 0; k < fired; k++) begin
            p.fired_valid = 1'b1; p.fired_id = ids[k]; p.rearmed = rea[k];
            p.last = (k == fired - 1);
            due_rsps.push_back(p);
         end
      end
   endtask

   // Driver: presents queued requests, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         predict_timers(req_payload);
         if (pending_reqs.size() != 0 && !hold_sender &&
             $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_reqs.pop_front();
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_reqs.size() != 0 && !hold_sender &&
                   $urandom_range(99) >= send_idle_pct) begin
         req_payload <= pending_reqs.pop_front();
         start <= 1'b1;
      end
   end

   // Monitor: each response transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         if (due_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_payload);
            failures <= failures + 1;
         end else begin
            want = due_rsps.pop_front();
            if (rsp_payload !== want) begin
               $display("%0t: expected %h, got %h", $time, want, rsp_payload);
               failures <= failures + 1;
            end
         end
      end
      if (cycles > CycleLimit) begin
         $display("timer_deadline_queue_top: mismatch");
         $finish;
      end
   end

   function automatic req_type make_req(input req_code_type op, input logic [15:0] id,
                                        input logic [47:0] dl, input logic [31:0] per,
                                        input logic [47:0] now);
      req_type r;
      r.req_type = op; r.timer_id = id; r.deadline = dl;
      r.repeat_period = per; r.current_time = now;
      return r;
   endfunction

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || start || busy || due_rsps.size() != 0)
         @(posedge clock);
   endtask

   // Mostly small ids and near times so that timers collide, fire and repeat.
   task automatic random_phase(input int count, input int idle);
      logic [47:0] now;
      logic [15:0] id;
      logic [31:0] per;
      int          sel;
      send_idle_pct = idle;
      now = 48'($urandom_range(1000));
      for (int n = 0; n < count; n++) begin
         id = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(40));
         per = ($urandom_range(2) == 0) ? 32'd0 :
               ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(300));
         sel = $urandom_range(99);
         if (sel < 50)
            pending_reqs.push_back(make_req(REQ_ADD, id,
               ($urandom_range(19) == 0) ? rand48() : now + 48'($urandom_range(400)),
               per, rand48()));
         else if (sel < 65)
            pending_reqs.push_back(make_req(REQ_DEL, id, rand48(), $urandom(), rand48()));
         else if (sel < 97) begin
            now = now + 48'($urandom_range(200));
            pending_reqs.push_back(make_req(REQ_TICK, 16'($urandom()), rand48(),
               $urandom(), ($urandom_range(29) == 0) ? rand48() : now));
         end else
            pending_reqs.push_back(make_req(REQ_NONE, 16'($urandom()), rand48(),
               $urandom(), rand48()));
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every request type, full table, saturation, fire cap.
      pending_reqs.push_back(make_req(REQ_TICK, 16'hFFFF, '1, '1, '1));
      pending_reqs.push_back(make_req(REQ_DEL, 16'h1234, '0, '0, '0));
      pending_reqs.push_back(make_req(REQ_ADD, 16'hFFFF, '1, '1, '0));
      pending_reqs.push_back(make_req(REQ_ADD, 16'h0000, '0, '0, '1));
      pending_reqs.push_back(make_req(REQ_ADD, 16'h0000, 48'd5, 32'd7, '0));
      pending_reqs.push_back(make_req(REQ_NONE, 16'hFFFF, '1, '1, '1));
      pending_reqs.push_back(make_req(REQ_TICK, '0, '0, '0, 48'hFFFF_FFFF_FFF0));
      pending_reqs.push_back(make_req(REQ_DEL, 16'hFFFF, '0, '0, '0));
      pending_reqs.push_back(make_req(REQ_DEL, 16'h0000, '0, '0, '0));
      for (int i = 0; i < Slots; i++)
         pending_reqs.push_back(make_req(REQ_ADD, 16'(100 + i), 48'(i % 3),
                                         (i % 2) ? 32'd0 : 32'd50, '0));
      pending_reqs.push_back(make_req(REQ_ADD, 16'd999, 48'd1, 32'd1, '0));
      pending_reqs.push_back(make_req(REQ_TICK, '0, '0, '0, 48'd10));
      pending_reqs.push_back(make_req(REQ_TICK, '0, '0, '0, '1));
      pending_reqs.push_back(make_req(REQ_TICK, '0, '0, '0, '1));
      wait_drained();

      // Once every response has come, hold the sender, then release it and carry on.
      hold_sender = 1'b1;
      repeat (5) @(posedge clock);
      hold_sender = 1'b0;

      for (int i = 0; i < Slots; i++)
         pending_reqs.push_back(make_req(REQ_DEL, 16'(100 + i), '0, '0, '0));
      pending_reqs.push_back(make_req(REQ_DEL, 16'd999, '0, '0, '0));
      wait_drained();

      random_phase(80, 0);
      random_phase(60, 61);
      random_phase(55, 6);
      random_phase(47, 0);

      repeat (200) @(posedge clock);
      if (failures == 0 && due_rsps.size() == 0)
         $display("timer_deadline_queue_top: match");
      else
         $display("timer_deadline_queue_top: mismatch");
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/tdq_pkg.sv
hw/rtl/tdq_store.sv
hw/rtl/timer_deadline_queue_top.sv
verif/timer_deadline_queue_top_tb.sv
